[src/fixed_timestep_accumulator_core_defines.svh]
// Assertion macros shared by the fixed-timestep accumulator RTL.
// No dependencies; included by the files that carry assertions.
`ifndef FIXED_TIMESTEP_ACCUMULATOR_CORE_DEFINES_SVH
`define FIXED_TIMESTEP_ACCUMULATOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define FTA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define FTA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FTA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define FTA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

[src/fta_pkg.sv]
// Shared types, widths, register indexes and the microcode program
// of the fixed-timestep accumulator. No dependencies.
package fta_pkg;

  localparam int TS_W       = 64;
  localparam int ACC_W      = 42;
  localparam int STEP_W     = 30;
  localparam int UPD_W      = 8;
  localparam int FRAC_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 42;
  localparam int UPC_W      = 4;

  localparam logic [CFG_IDX_W-1:0] REG_FIXED_STEP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_FRAME   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_UPDATES = 2'd2;

  localparam logic [STEP_W-1:0] RST_FIXED_STEP  = 30'd16666666;
  localparam logic [ACC_W-1:0]  RST_MAX_FRAME   = 42'd250000000;
  localparam logic [UPD_W-1:0]  RST_MAX_UPDATES = 8'd8;

  // Program addresses
  localparam logic [UPC_W-1:0] ST_WAIT  = 4'd0;
  localparam logic [UPC_W-1:0] ST_DELTA = 4'd1;
  localparam logic [UPC_W-1:0] ST_CLAMP = 4'd2;
  localparam logic [UPC_W-1:0] ST_ACCUM = 4'd3;
  localparam logic [UPC_W-1:0] ST_QDIV  = 4'd4;
  localparam logic [UPC_W-1:0] ST_WHOLE = 4'd5;
  localparam logic [UPC_W-1:0] ST_TICK  = 4'd6;
  localparam logic [UPC_W-1:0] ST_FDIV  = 4'd7;
  localparam logic [UPC_W-1:0] ST_EMIT  = 4'd8;
  localparam logic [UPC_W-1:0] ST_DONE  = 4'd9;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_WAIT,
    OP_DELTA,
    OP_CLAMP,
    OP_ACCUM,
    OP_DIV,
    OP_WHOLE,
    OP_TICK,
    OP_EMIT
  } op_e;

  typedef enum logic [2:0] {
    COND_NEXT,
    COND_JUMP,
    COND_NO_INPUT,
    COND_CNT_NZ,
    COND_OUT_BUSY
  } cond_e;

  typedef struct packed {
    op_e              op;
    cond_e            cond;
    logic [UPC_W-1:0] target;
  } ctl_word_t;

  typedef struct packed {
    logic in_valid;
    logic cnt_nz;
    logic out_busy;
  } seq_status_t;

  // Microcode ROM: one control word per program address.
  function automatic ctl_word_t prog_word(input logic [UPC_W-1:0] addr);
    ctl_word_t w;
    case (addr)
      ST_WAIT:  w = '{op: OP_WAIT,  cond: COND_NO_INPUT, target: ST_WAIT};
      ST_DELTA: w = '{op: OP_DELTA, cond: COND_NEXT,     target: ST_WAIT};
      ST_CLAMP: w = '{op: OP_CLAMP, cond: COND_NEXT,     target: ST_WAIT};
      ST_ACCUM: w = '{op: OP_ACCUM, cond: COND_NEXT,     target: ST_WAIT};
      ST_QDIV:  w = '{op: OP_DIV,   cond: COND_CNT_NZ,   target: ST_QDIV};
      ST_WHOLE: w = '{op: OP_WHOLE, cond: COND_NEXT,     target: ST_WAIT};
      ST_TICK:  w = '{op: OP_TICK,  cond: COND_NEXT,     target: ST_WAIT};
      ST_FDIV:  w = '{op: OP_DIV,   cond: COND_CNT_NZ,   target: ST_FDIV};
      ST_EMIT:  w = '{op: OP_EMIT,  cond: COND_OUT_BUSY, target: ST_EMIT};
      ST_DONE:  w = '{op: OP_NOP,   cond: COND_JUMP,     target: ST_WAIT};
      default:  w = '{op: OP_NOP,   cond: COND_JUMP,     target: ST_WAIT};
    endcase
    return w;
  endfunction

endpackage

[src/fta_if.sv]
// Valid/ready channel interfaces of the fixed-timestep accumulator:
// frame input, result output and register write. Depends on fta_pkg.
interface fta_in_if;
  import fta_pkg::*;
  logic             valid;
  logic             ready;
  logic [TS_W-1:0]  now_ns;
  logic             restart;
  modport source (output valid, now_ns, restart, input ready);
  modport sink   (input valid, now_ns, restart, output ready);
endinterface

interface fta_out_if;
  import fta_pkg::*;
  logic              valid;
  logic              ready;
  logic [UPD_W-1:0]  step_count;
  logic [ACC_W-1:0]  frame_delta_ns;
  logic [FRAC_W-1:0] interp_fraction;
  logic              clock_regressed;
  logic              backlog_dropped;
  logic [TS_W-1:0]   first_tick;
  logic [TS_W-1:0]   frame_number;
  modport source (output valid, step_count, frame_delta_ns, interp_fraction,
                  clock_regressed, backlog_dropped, first_tick, frame_number,
                  input ready);
  modport sink   (input valid, step_count, frame_delta_ns, interp_fraction,
                  clock_regressed, backlog_dropped, first_tick, frame_number,
                  output ready);
endinterface

interface fta_cfg_if;
  import fta_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[src/fta_seq.sv]
// Microcode sequencer: program counter, ROM lookup and branch logic.
// Depends on fta_pkg.
module fta_seq (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  fta_pkg::seq_status_t       status_i,
  output fta_pkg::ctl_word_t         ctl_o,
  output logic [fta_pkg::UPC_W-1:0]  upc_o
);
  import fta_pkg::*;

  logic [UPC_W-1:0] upc_q, upc_d;
  logic             take;

  assign ctl_o = prog_word(upc_q);
  assign upc_o = upc_q;

  always_comb begin
    case (ctl_o.cond)
      COND_NEXT:     take = 1'b0;
      COND_JUMP:     take = 1'b1;
      COND_NO_INPUT: take = !status_i.in_valid;
      COND_CNT_NZ:   take = status_i.cnt_nz;
      COND_OUT_BUSY: take = status_i.out_busy;
      default:       take = 1'b1;
    endcase
    upc_d = take ? ctl_o.target : upc_q + UPC_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= ST_WAIT;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

[src/fixed_timestep_accumulator_core.sv]
// Channel   | Dir | Payload                                          | Accepted at
// in_i      | in  | now_ns[64], restart                              | valid & ready
// res_o     | out | step_count, frame_delta_ns, interp_fraction,     | valid & ready
//           |     | clock_regressed, backlog_dropped, first_tick,    |
//           |     | frame_number                                     |
// cfg_i     | in  | index[2], data[42]                               | valid & ready
//
// One item at a time: one shared restoring divider runs 42 quotient
// iterations and then FRACTION_BITS fraction iterations per item. The next
// item is taken after the result loads into the output register, once the
// sequencer has passed its done state back to the wait state.
// rst_ni (async, low) resets the configuration registers, state and the sequencer.
// A stalled result holds in the output register; the next item is taken
// while it waits, and only the final write waits for the slot to clear.
// Register writes are accepted in every cycle.
//
// Top level: microcoded datapath. Depends on fta_pkg, fta_if, fta_seq
// and fixed_timestep_accumulator_core_defines.svh.
`include "fixed_timestep_accumulator_core_defines.svh"

module fixed_timestep_accumulator_core #(
  parameter int FRACTION_BITS = 16
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  fta_in_if.sink     in_i,
  fta_out_if.source  res_o,
  fta_cfg_if.sink    cfg_i
);
  import fta_pkg::*;

  localparam int CntW = $clog2(ACC_W);

  // Configuration registers
  logic [STEP_W-1:0] step_cfg_q;
  logic [ACC_W-1:0]  max_frame_q;
  logic [UPD_W-1:0]  mu_q;

  // Persistent state
  logic [TS_W-1:0]  base_q;
  logic             base_valid_q;
  logic [ACC_W-1:0] accum_q;
  logic [TS_W-1:0]  tick_q;
  logic [TS_W-1:0]  frame_q;

  // Per-item working registers
  logic [TS_W-1:0]   now_q;
  logic              restart_q;
  logic [TS_W-1:0]   delta_q;
  logic              regressed_q;
  logic [ACC_W-1:0]  d_q;      // dividend in, quotient out
  logic [STEP_W-1:0] r_q;      // partial remainder
  logic [CntW-1:0]   cnt_q;
  logic [UPD_W-1:0]  steps_q;
  logic              dropped_q;
  logic [TS_W-1:0]   first_tick_q;
  logic [TS_W-1:0]   frame_num_q;

  // Output register
  logic              out_valid_q;
  logic [UPD_W-1:0]  o_steps_q;
  logic [ACC_W-1:0]  o_delta_q;
  logic [FRAC_W-1:0] o_frac_q;
  logic              o_regressed_q;
  logic              o_dropped_q;
  logic [TS_W-1:0]   o_first_tick_q;
  logic [TS_W-1:0]   o_frame_num_q;

  ctl_word_t        ctl;
  seq_status_t      status;
  logic [UPC_W-1:0] upc;

  logic              out_busy;
  logic              out_load;
  logic              in_fire;
  logic [STEP_W-1:0] step_w;
  logic [STEP_W:0]   div_t;
  logic [STEP_W:0]   div_sub;
  logic              div_ge;
  logic [ACC_W:0]    sum;
  logic              quot_gt;

  fta_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctl_o    (ctl),
    .upc_o    (upc)
  );

  // A zero step register counts as one nanosecond.
  assign step_w = (step_cfg_q == '0) ? STEP_W'(1) : step_cfg_q;

  assign out_busy = out_valid_q && !res_o.ready;
  assign out_load = (ctl.op == OP_EMIT) && !out_busy;
  assign in_fire  = (ctl.op == OP_WAIT) && in_i.valid;

  assign status.in_valid = in_i.valid;
  assign status.cnt_nz   = (cnt_q != '0);
  assign status.out_busy = out_busy;

  assign in_i.ready  = (ctl.op == OP_WAIT);
  assign cfg_i.ready = 1'b1;

  // One restoring-division iteration: shift in the dividend MSB, try
  // to subtract the step, shift the quotient bit into the dividend.
  assign div_t   = {r_q, d_q[ACC_W-1]};
  assign div_sub = div_t - {1'b0, step_w};
  assign div_ge  = (div_t >= {1'b0, step_w});

  assign sum     = {1'b0, accum_q} + {1'b0, delta_q[ACC_W-1:0]};
  assign quot_gt = (d_q > {{(ACC_W-UPD_W){1'b0}}, mu_q});

  // Register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_cfg_q  <= RST_FIXED_STEP;
      max_frame_q <= RST_MAX_FRAME;
      mu_q        <= RST_MAX_UPDATES;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_FIXED_STEP:  step_cfg_q  <= cfg_i.data[STEP_W-1:0];
        REG_MAX_FRAME:   max_frame_q <= cfg_i.data[ACC_W-1:0];
        REG_MAX_UPDATES: mu_q        <= cfg_i.data[UPD_W-1:0];
        default: ;  // writes beyond the register list drop
      endcase
    end
  end

  // Persistent state and sequencing control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q       <= '0;
      base_valid_q <= 1'b0;
      accum_q      <= '0;
      tick_q       <= '0;
      frame_q      <= '0;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      case (ctl.op)
        OP_DELTA: begin
          base_q <= now_q;
          if (restart_q || !base_valid_q) begin
            base_valid_q <= 1'b1;
          end
        end
        OP_ACCUM: begin
          cnt_q <= CntW'(ACC_W - 1);
        end
        OP_DIV: begin
          cnt_q <= cnt_q - CntW'(1);
        end
        OP_WHOLE: begin
          // The remainder is the new backlog whether or not the budget hit.
          accum_q <= {{(ACC_W-STEP_W){1'b0}}, r_q};
          cnt_q   <= CntW'(FRACTION_BITS - 1);
        end
        OP_TICK: begin
          tick_q  <= tick_q + {{(TS_W-UPD_W){1'b0}}, steps_q};
          frame_q <= frame_q + TS_W'(1);
        end
        default: ;
      endcase

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath working registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      now_q     <= in_i.now_ns;
      restart_q <= in_i.restart;
    end
    case (ctl.op)
      OP_DELTA: begin
        regressed_q <= 1'b0;
        delta_q     <= '0;
        if (!(restart_q || !base_valid_q)) begin
          if (now_q >= base_q) begin
            delta_q <= now_q - base_q;
          end else begin
            regressed_q <= 1'b1;
          end
        end
      end
      OP_CLAMP: begin
        if (delta_q > {{(TS_W-ACC_W){1'b0}}, max_frame_q}) begin
          delta_q <= {{(TS_W-ACC_W){1'b0}}, max_frame_q};
        end
      end
      OP_ACCUM: begin
        // Saturate to the frame limit on a 42-bit overflow.
        d_q <= sum[ACC_W] ? max_frame_q : sum[ACC_W-1:0];
        r_q <= '0;
      end
      OP_DIV: begin
        d_q <= {d_q[ACC_W-2:0], div_ge};
        r_q <= div_ge ? div_sub[STEP_W-1:0] : div_t[STEP_W-1:0];
      end
      OP_WHOLE: begin
        steps_q   <= quot_gt ? mu_q : d_q[UPD_W-1:0];
        dropped_q <= quot_gt;
        d_q       <= '0;   // fraction phase shifts in zeros
      end
      OP_TICK: begin
        first_tick_q <= tick_q;
        frame_num_q  <= frame_q;
      end
      default: ;
    endcase

    if (out_load) begin
      o_steps_q      <= steps_q;
      o_delta_q      <= delta_q[ACC_W-1:0];
      o_frac_q       <= d_q[FRAC_W-1:0];
      o_regressed_q  <= regressed_q;
      o_dropped_q    <= dropped_q;
      o_first_tick_q <= first_tick_q;
      o_frame_num_q  <= frame_num_q;
    end
  end

  assign res_o.valid           = out_valid_q;
  assign res_o.step_count      = o_steps_q;
  assign res_o.frame_delta_ns  = o_delta_q;
  assign res_o.interp_fraction = o_frac_q;
  assign res_o.clock_regressed = o_regressed_q;
  assign res_o.backlog_dropped = o_dropped_q;
  assign res_o.first_tick      = o_first_tick_q;
  assign res_o.frame_number    = o_frame_num_q;

  `FTA_ASSERT_IMPL(a_rem_below_step, clk_i, rst_ni, upc == ST_WHOLE, r_q < step_w, "rem >= step")
  `FTA_ASSERT_IMPL(a_steps_budget, clk_i, rst_ni, upc == ST_TICK, steps_q <= mu_q, "over budget")
  `FTA_ASSERT_IMPL(a_drop, clk_i, rst_ni, upc == ST_TICK && dropped_q, steps_q == mu_q, "early drop")
  `FTA_ASSERT_NEXT(a_emit_loads, clk_i, rst_ni, out_load, out_valid_q, "result lost")
  `FTA_ASSERT_IMPL(a_src, clk_i, rst_ni, $rose(out_valid_q), $past(upc) == ST_EMIT, "stray valid")

endmodule
